[hdl/sm3_hash_engine_defines.svh]
// Assertion macros for the SM3 hash engine.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SM3_HASH_ENGINE_DEFINES_SVH
`define SM3_HASH_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define SM3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SM3_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SM3_ASSERT(label, clk, rst_n, prop, msg)
`define SM3_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hdl/sm3_pkg.sv]
// Shared types, constants and round functions for the SM3 hash engine.
// No dependencies.
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [255:0] IV_VALUE = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    // Block handed from packer to compressor
    typedef struct packed {
        logic [511:0] words;       // word 0 in the top bits
        logic         final_block; // emit digest afterwards
    } blk_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } item_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

[hdl/sm3_front.sv]
// Front end: packs message bytes into 64-byte blocks and appends padding.
// Depends on sm3_pkg.
module sm3_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sm3_pkg::item_t     in_item,
    output logic               blk_valid,
    input  logic               blk_ready,
    output sm3_pkg::blk_t      blk
);
    import sm3_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_SEND = 4'b0100,
        S_LEN  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [511:0]  buf_reg, buf_next;
    logic [60:0]   count_reg, count_next;
    logic          final_reg, final_next;
    logic          last_reg, last_next;   // message closing in progress
    logic [5:0]    pos_reg, pos_next;     // pad byte position
    logic          out_valid_reg, out_valid_next;
    blk_t          out_reg, out_next;
    // Set when the pad marker spilled into a block with no room for the length
    logic          overflow_pad_reg, overflow_pad_next;

    logic          out_free;
    logic [5:0]    byte_pos;
    logic [63:0]   bit_len;

    assign out_free  = !out_valid_reg || blk_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign blk_valid = out_valid_reg;
    assign blk       = out_reg;
    assign byte_pos  = count_reg[5:0];
    assign bit_len   = {count_reg, 3'b000};

    always_comb
    begin
        state_next     = state_reg;
        buf_next       = buf_reg;
        count_next     = count_reg;
        final_next     = final_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !blk_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    last_next = in_item.last;
                    pos_next  = byte_pos;
                    if (in_item.has_byte)
                    begin
                        buf_next[511 - 8 * byte_pos -: 8] = in_item.data;
                        count_next = count_reg + 61'd1;
                        pos_next   = byte_pos + 6'd1;
                        if (byte_pos == 6'd63)
                        begin
                            final_next = 1'b0;
                            state_next = S_SEND;
                        end
                        else if (in_item.last)
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (in_item.last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                // place the marker byte and clear the tail
                for (int i = 0; i < 64; i++)
                begin
                    if (6'(i) == pos_reg)
                        buf_next[511 - 8 * i -: 8] = PAD_BYTE;
                    else if (6'(i) > pos_reg)
                        buf_next[511 - 8 * i -: 8] = 8'h00;
                end
                if (pos_reg > 6'd55)
                begin
                    final_next = 1'b0;
                    state_next = S_SEND;
                    pos_next   = 6'd0;
                    last_next  = 1'b0;
                    final_next = 1'b0;
                end
                else
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                buf_next[63:0] = bit_len;
                final_next = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_next.words       = buf_reg;
                    out_next.final_block = final_reg;
                    if (final_reg)
                    begin
                        count_next = '0;
                        final_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (pos_reg == 6'd0 && !last_reg)
                    begin
                        // full data block; overflow pad needs a zero block
                        state_next = S_IDLE;
                        if (!last_reg && overflow_pad_reg)
                        begin
                            buf_next   = '0;
                            state_next = S_LEN;
                        end
                    end
                    else
                    begin
                        // byte completed a block and item closes the message
                        buf_next   = '0;
                        buf_next[511 -: 8] = PAD_BYTE;
                        pos_next   = 6'd0;
                        state_next = S_LEN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        overflow_pad_next = overflow_pad_reg;
        if (state_reg == S_PAD)
            overflow_pad_next = (pos_reg > 6'd55);
        else if (state_reg == S_SEND && out_free)
            overflow_pad_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            final_reg        <= 1'b0;
            last_reg         <= 1'b0;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
            overflow_pad_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            final_reg        <= final_next;
            last_reg         <= last_next;
            pos_reg          <= pos_next;
            out_valid_reg    <= out_valid_next;
            overflow_pad_reg <= overflow_pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        out_reg <= out_next;
    end

endmodule

[hdl/sm3_queue.sv]
// Two-entry block queue between packer and compressor.
// Depends on sm3_pkg.
module sm3_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  sm3_pkg::blk_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output sm3_pkg::blk_t rd_data
);
    import sm3_pkg::*;

    blk_t       mem_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= !wp_reg;
            if (do_rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

[hdl/sm3_core.sv]
// Back end: 64-round SM3 compression, one round per cycle, and digest output.
// Depends on sm3_pkg and sm3_hash_engine_defines.svh.
`include "sm3_hash_engine_defines.svh"
module sm3_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          blk_valid,
    output logic          blk_ready,
    input  sm3_pkg::blk_t blk,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_word,
    output logic [2:0]    out_index,
    output logic          out_last
);
    import sm3_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_EMIT  = 3'b100
    } cstate_t;

    cstate_t      state_reg, state_next;
    logic [255:0] cv_reg, cv_next;
    logic [255:0] wr_reg, wr_next;    // A..H, A on top
    logic [511:0] win_reg, win_next;  // W[j..j+15], W[j] on top
    logic [5:0]   rnd_reg, rnd_next;
    logic         fin_reg, fin_next;
    logic [2:0]   idx_reg, idx_next;

    logic [31:0] a, b, c, d, e, f, g, h, wj, wj4, wn, tj;
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
    logic [255:0] round_out;

    assign {a, b, c, d, e, f, g, h} = wr_reg;
    assign wj  = win_reg[511 -: 32];
    assign wj4 = win_reg[511 - 128 -: 32];
    // W[j+16] from the window
    assign wn = perm1(win_reg[511 -: 32] ^ win_reg[511 - 224 -: 32]
                      ^ rotl(win_reg[511 - 416 -: 32], 5'd15))
                ^ rotl(win_reg[511 - 96 -: 32], 5'd7) ^ win_reg[511 - 320 -: 32];
    assign tj  = (rnd_reg < 6'd16) ? T_LOW : T_HIGH;
    assign a12 = rotl(a, 5'd12);
    assign ss1 = rotl(a12 + e + rotl(tj, rnd_reg[4:0]), 5'd7);
    assign ss2 = ss1 ^ a12;
    assign ff  = (rnd_reg < 6'd16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
    assign gg  = (rnd_reg < 6'd16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
    assign tt1 = ff + d + ss2 + (wj ^ wj4);
    assign tt2 = gg + h + ss1 + wj;
    assign round_out = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};

    assign blk_ready = (state_reg == C_IDLE);
    assign out_valid = (state_reg == C_EMIT);
    assign out_word  = cv_reg[255 - 32 * idx_reg -: 32];
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        cv_next    = cv_reg;
        wr_next    = wr_reg;
        win_next   = win_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        idx_next   = idx_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (blk_valid)
                begin
                    win_next   = blk.words;
                    wr_next    = cv_reg;
                    fin_next   = blk.final_block;
                    rnd_next   = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                wr_next  = round_out;
                win_next = {win_reg[479:0], wn};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    cv_next    = cv_reg ^ round_out;
                    idx_next   = '0;
                    state_next = fin_reg ? C_EMIT : C_IDLE;
                end
            end
            C_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cv_next    = IV_VALUE;
                        state_next = C_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cv_reg    <= IV_VALUE;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cv_reg    <= cv_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_reg  <= wr_next;
        win_reg <= win_next;
    end

    `SM3_ASSERT(a_round_wrap, clk, rst_n, (state_reg == C_ROUND && rnd_reg == 6'd63) |=> (state_reg != C_ROUND), "compression ran past round 63")
    `SM3_NEVER(a_emit_no_take, clk, rst_n, (state_reg == C_EMIT) && blk_ready, "block taken while digest pending")
    `SM3_ASSERT(a_iv_after, clk, rst_n, (state_reg == C_EMIT && out_ready && idx_reg == 3'd7) |=> (cv_reg == IV_VALUE), "chain value not restored")

endmodule

[hdl/sm3_hash_engine.sv]
// Top level of the SM3 hash engine: packer, block queue, compressor.
// Depends on sm3_pkg, sm3_front, sm3_queue, sm3_core.
//
//  channel  | handshake            | payload
//  input    | in_valid / in_ready  | msg_byte, no_byte, is_last
//  output   | out_valid / out_ready| digest_word, word_index, last_word
//
// One byte per cycle is taken while the packer has room; after the 64th byte
// the packer hands the block on once its output is free. The compressor
// loads a block while idle, then runs its 64 rounds. Closing a message takes
// the packer's pad, length and send states plus one or two compressions, then
// eight output beats. The two-entry queue lets bytes of the next block arrive
// during rounds. Reset loads the initial vector; no clearing pass.
module sm3_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        no_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sm3_pkg::*;

    item_t item;
    blk_t  f_blk, q_blk;
    logic  f_valid, f_ready, q_valid, q_ready;

    assign item.data     = msg_byte;
    assign item.has_byte = !no_byte;
    assign item.last     = is_last;

    sm3_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_item(item),
        .blk_valid(f_valid), .blk_ready(f_ready), .blk(f_blk));

    sm3_queue u_queue (
        .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_blk));

    sm3_core u_core (
        .clk, .rst_n, .blk_valid(q_valid), .blk_ready(q_ready), .blk(q_blk),
        .out_valid, .out_ready, .out_word(digest_word),
        .out_index(word_index), .out_last(last_word));

endmodule
